// ===== rtl/rsc_pkg.sv =====
// Shared constants and helpers for the radix string converter.
package rsc_pkg;

   // base codes, as used on the configuration port and in the result tuser
   localparam logic [1:0] BASE_BIN = 2'd0;
   localparam logic [1:0] BASE_OCT = 2'd1;
   localparam logic [1:0] BASE_DEC = 2'd2;
   localparam logic [1:0] BASE_HEX = 2'd3;

   // target code that asks for all four bases in turn (and codes above it)
   localparam logic [2:0] TARGET_ALL = 3'd4;

   // configuration register indexes
   localparam logic CSR_SOURCE = 1'b0;
   localparam logic CSR_TARGET = 1'b1;

   // ASCII characters
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_F = 8'h46;
   localparam logic [7:0] CHAR_7 = 8'h37;

   // radix limits for the digit range check
   localparam logic [4:0] RADIX_BIN = 5'd2;
   localparam logic [4:0] RADIX_OCT = 5'd8;
   localparam logic [4:0] RADIX_DEC = 5'd10;
   localparam logic [4:0] RADIX_HEX = 5'd16;

   // uppercase ASCII glyph of a digit value
   function automatic logic [7:0] glyph(input logic [3:0] d);
      logic [7:0] g;
      if (d < 4'd10) begin
         g = CHAR_0 + {4'b0000, d};
      end else begin
         g = CHAR_7 + {4'b0000, d};
      end
      return g;
   endfunction

endpackage

// ===== rtl/radix_string_converter_core.sv =====
// Top level of the radix string converter: accumulate, convert, emit digits.
//
// Input channel (req_): one ASCII digit character per word, most significant
// first; tlast marks the final character of a number. Characters before the
// last are folded into the accumulator at one word per cycle.
// Result channel (rsp_): one ASCII digit per word, most significant first, no
// leading zeros; tlast marks the final word of the run. An invalid character
// anywhere in the number gives one error word instead.
// Configuration (csr_): index 0 source base, index 1 target base; write only
// while the block is idle.
// After the last character a load step fills the digit shift register, which
// holds WORD_BITS digit positions for binary, WORD_BITS/3 and WORD_BITS/4
// rounded up for octal and hex. Decimal first waits on the bit-serial BCD
// converter and then shifts out its NDEC decimal positions. Leading zero
// positions are dropped without a word. Target "all" chains the four bases.
// A result register sits on the output: the next number is accepted while the
// final word still waits. When the receiver stalls, digit emission holds.
// Reset clears the accumulator and sets source base decimal, target binary.
module radix_string_converter_core
   import rsc_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [3:0] rsp_tuser,   // [1:0] out_base, [2] base_done, [3] bad_digit
   output logic       rsp_tlast,
   input  logic       csr_wen,
   input  logic       csr_index,
   input  logic [2:0] csr_wdata
);

   localparam int NDEC   = (WORD_BITS * 30103) / 100000 + 1;
   localparam int ND_OCT = (WORD_BITS + 2) / 3;
   localparam int ND_HEX = (WORD_BITS + 3) / 4;
   localparam int EW     = (4 * NDEC > 3 * ND_OCT) ? 4 * NDEC : 3 * ND_OCT;
   localparam int SH_BIN = EW - WORD_BITS;
   localparam int SH_OCT = EW - 3 * ND_OCT;
   localparam int SH_HEX = EW - 4 * ND_HEX;
   localparam int SH_DEC = EW - 4 * NDEC;
   localparam int CW     = $clog2(WORD_BITS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_BCD   = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_ERR   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           src_ff;
   logic [2:0]           tgt_ff;
   logic [WORD_BITS-1:0] acc_ff, acc_in, acc_next;
   logic                 bad_ff, bad_in;
   logic [1:0]           base_ff, base_in;
   logic                 all_ff, all_in;
   logic [EW-1:0]        dig_ff, dig_in, dig_shift;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 lead_ff, lead_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           char_ff;
   logic [1:0]           obase_ff;
   logic                 odone_ff, olast_ff, obad_ff;

   logic                 out_load;
   logic [7:0]           o_char;
   logic [1:0]           o_base;
   logic                 o_done, o_last, o_bad;

   logic                 bcd_start, bcd_done;
   logic [4*NDEC-1:0]    bcd_val;

   logic [3:0]           dv;
   logic                 is_num, is_alpha, dig_ok;
   logic [4:0]           radix_lim;
   logic [3:0]           top_dig;
   logic                 emit, slot_free;

   rsc_bcd #(
      .WORD_BITS (WORD_BITS),
      .NDEC      (NDEC)
   ) u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .value (acc_ff),
      .done  (bcd_done),
      .bcd   (bcd_val)
   );

   // digit value of the incoming character and its range check
   always_comb begin
      is_num   = (req_tdata >= CHAR_0) && (req_tdata <= CHAR_9);
      is_alpha = (req_tdata >= CHAR_A) && (req_tdata <= CHAR_F);
      dv       = is_num ? 4'(req_tdata - CHAR_0) : 4'(req_tdata - CHAR_7);
      case (src_ff)
         BASE_BIN: radix_lim = RADIX_BIN;
         BASE_OCT: radix_lim = RADIX_OCT;
         BASE_DEC: radix_lim = RADIX_DEC;
         default:  radix_lim = RADIX_HEX;
      endcase
      dig_ok = (is_num || is_alpha) && ({1'b0, dv} < radix_lim);
   end

   // fold the digit in; an invalid one counts as zero
   always_comb begin
      logic [WORD_BITS-1:0] d;
      d = dig_ok ? WORD_BITS'(dv) : '0;
      case (src_ff)
         BASE_BIN: acc_next = (acc_ff << 1) + d;
         BASE_OCT: acc_next = (acc_ff << 3) + d;
         BASE_DEC: acc_next = (acc_ff << 3) + (acc_ff << 1) + d;
         default:  acc_next = (acc_ff << 4) + d;
      endcase
   end

   // top digit of the shift register and the shift by one digit
   always_comb begin
      case (base_ff)
         BASE_BIN: begin
            top_dig   = {3'b000, dig_ff[EW-1]};
            dig_shift = dig_ff << 1;
         end
         BASE_OCT: begin
            top_dig   = {1'b0, dig_ff[EW-1 -: 3]};
            dig_shift = dig_ff << 3;
         end
         default: begin
            top_dig   = dig_ff[EW-1 -: 4];
            dig_shift = dig_ff << 4;
         end
      endcase
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign emit      = lead_ff || (top_dig != 4'd0) || (cnt_ff == CW'(1));

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      bad_in    = bad_ff;
      base_in   = base_ff;
      all_in    = all_ff;
      dig_in    = dig_ff;
      cnt_in    = cnt_ff;
      lead_in   = lead_ff;
      bcd_start = 1'b0;
      out_load  = 1'b0;
      o_char    = glyph(top_dig);
      o_base    = base_ff;
      o_done    = (cnt_ff == CW'(1));
      o_last    = (cnt_ff == CW'(1)) && (!all_ff || (base_ff == BASE_HEX));
      o_bad     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               acc_in = acc_next;
               bad_in = bad_ff || !dig_ok;
               if (req_tlast) begin
                  if (bad_ff || !dig_ok) begin
                     state_in = ST_ERR;
                  end else begin
                     all_in   = (tgt_ff >= TARGET_ALL);
                     base_in  = (tgt_ff >= TARGET_ALL) ? BASE_BIN : tgt_ff[1:0];
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            lead_in = 1'b0;
            case (base_ff)
               BASE_BIN: begin
                  dig_in   = EW'(acc_ff) << SH_BIN;
                  cnt_in   = CW'(WORD_BITS);
                  state_in = ST_SHIFT;
               end
               BASE_OCT: begin
                  dig_in   = EW'(acc_ff) << SH_OCT;
                  cnt_in   = CW'(ND_OCT);
                  state_in = ST_SHIFT;
               end
               BASE_DEC: begin
                  bcd_start = 1'b1;
                  state_in  = ST_BCD;
               end
               default: begin
                  dig_in   = EW'(acc_ff) << SH_HEX;
                  cnt_in   = CW'(ND_HEX);
                  state_in = ST_SHIFT;
               end
            endcase
         end
         ST_BCD: begin
            if (bcd_done) begin
               dig_in   = EW'(bcd_val) << SH_DEC;
               cnt_in   = CW'(NDEC);
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // drop leading zeros freely; hold a digit until the slot frees
            if (!emit || slot_free) begin
               dig_in = dig_shift;
               cnt_in = cnt_ff - CW'(1);
               if (emit) begin
                  out_load = 1'b1;
                  lead_in  = 1'b1;
                  if (cnt_ff == CW'(1)) begin
                     if (all_ff && (base_ff != BASE_HEX)) begin
                        base_in  = base_ff + 2'd1;
                        state_in = ST_LOAD;
                     end else begin
                        acc_in   = '0;
                        bad_in   = 1'b0;
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         ST_ERR: begin
            o_char = 8'h00;
            o_base = BASE_BIN;
            o_done = 1'b1;
            o_last = 1'b1;
            o_bad  = 1'b1;
            if (slot_free) begin
               out_load = 1'b1;
               acc_in   = '0;
               bad_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff       <= BASE_DEC;
         tgt_ff       <= {1'b0, BASE_BIN};
         acc_ff       <= '0;
         bad_ff       <= 1'b0;
         base_ff      <= BASE_BIN;
         all_ff       <= 1'b0;
         cnt_ff       <= '0;
         lead_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         bad_ff       <= bad_in;
         base_ff      <= base_in;
         all_ff       <= all_in;
         cnt_ff       <= cnt_in;
         lead_ff      <= lead_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_SOURCE: src_ff <= csr_wdata[1:0];
               CSR_TARGET: tgt_ff <= csr_wdata;
               default:    src_ff <= src_ff;
            endcase
         end
      end
      dig_ff <= dig_in;
      if (out_load) begin
         char_ff  <= o_char;
         obase_ff <= o_base;
         odone_ff <= o_done;
         olast_ff <= o_last;
         obad_ff  <= o_bad;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tuser  = {obad_ff, odone_ff, obase_ff};
   assign rsp_tlast  = olast_ff;

   // the final word of a run always closes a base string
   a_last_closes_base: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[2])
      else $error("run ends inside a base string");

   // an error word stands alone, carries no character and ends the run
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[3]) |-> (rsp_tlast && (rsp_tdata == 8'h00)))
      else $error("malformed error word");

   // no further character is taken once the last one is in
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input accepted during conversion");

   // the BCD converter finishes only while it is awaited
   a_bcd_done_state: assert property (@(posedge clock) disable iff (reset)
      bcd_done |-> (state_ff == ST_BCD))
      else $error("BCD result outside wait state");

endmodule

// ===== rtl/rsc_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module rsc_bcd #(
   parameter int WORD_BITS = 32,
   parameter int NDEC      = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [WORD_BITS-1:0]   value,
   output logic                   done,
   output logic [4*NDEC-1:0]      bcd
);

   localparam int CW = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0] bin_ff, bin_in;
   logic [4*NDEC-1:0]    bcd_ff, bcd_in;
   logic [4*NDEC-1:0]    adj;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   // add 3 to every digit of 5 or more before the next doubling
   always_comb begin
      for (int i = 0; i < NDEC; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                    : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in = value;
         bcd_in = '0;
         cnt_in = CW'(WORD_BITS);
      end else if (cnt_ff != '0) begin
         bin_in  = bin_ff << 1;
         bcd_in  = {adj[4*NDEC-2:0], bin_ff[WORD_BITS-1]};
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule
